### design/gpmix_pkg.sv
// ---------------------------------------------------------------------------
// gpmix_pkg
// Shared widths, codes and constants of the gamepad wheel velocity mixer.
// ---------------------------------------------------------------------------
`default_nettype none

package gpmix_pkg;

	// field widths
	localparam int BTN_W   = 8;
	localparam int RPM_W   = 12;
	localparam int WHEEL_W = 14;
	localparam int LED_W   = 4;
	localparam int AXIS_W  = 8;
	localparam int MAP_W   = 13;
	localparam int PROD_W  = BTN_W + RPM_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// full-scale value of an analog button or stick axis
	localparam int AXIS_FULL_SCALE = 255;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STICK_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BTN_MAX   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BTN_THR   = 2'd3;

	// register reset values
	localparam int RST_DEADBAND  = 50;
	localparam int RST_STICK_MAX = 1500;
	localparam int RST_BTN_MAX   = 1000;
	localparam int RST_BTN_THR   = 0;

	// stick slope = stick_max / (128 - deadband/2)
	localparam int DEADZONE_BASE = 128;
	localparam int SLOPE_RST = RST_STICK_MAX / (DEADZONE_BASE - RST_DEADBAND / 2);

	// LED patterns, low active
	localparam logic [LED_W-1:0] LED_FWD  = 4'b0111;
	localparam logic [LED_W-1:0] LED_BWD  = 4'b1011;
	localparam logic [LED_W-1:0] LED_RGT  = 4'b1101;
	localparam logic [LED_W-1:0] LED_LFT  = 4'b1110;
	localparam logic [LED_W-1:0] LED_IDLE = 4'b1111;

	// drive mode picked for one sample
	typedef enum logic [2:0] {
		MODE_OFF,
		MODE_UP,
		MODE_DOWN,
		MODE_RIGHT,
		MODE_LEFT,
		MODE_R2,
		MODE_L2,
		MODE_STICK
	} mode_t;

endpackage

`default_nettype wire

### design/gpmix_if.sv
// ---------------------------------------------------------------------------
// gpmix_if
// Valid/ready channels: gamepad sample in, wheel command out.
// ---------------------------------------------------------------------------
`default_nettype none

interface gpmix_pad_if;
	logic                         valid;
	logic                         ready;
	logic                         connected;
	logic [gpmix_pkg::BTN_W-1:0]  btn_up;
	logic [gpmix_pkg::BTN_W-1:0]  btn_down;
	logic [gpmix_pkg::BTN_W-1:0]  btn_right;
	logic [gpmix_pkg::BTN_W-1:0]  btn_left;
	logic [gpmix_pkg::BTN_W-1:0]  btn_r2;
	logic [gpmix_pkg::BTN_W-1:0]  btn_l2;
	logic [gpmix_pkg::AXIS_W-1:0] stick_x;
	logic [gpmix_pkg::AXIS_W-1:0] stick_y;

	modport source (
		output valid, connected, btn_up, btn_down, btn_right, btn_left,
		       btn_r2, btn_l2, stick_x, stick_y,
		input  ready
	);
	modport sink (
		input  valid, connected, btn_up, btn_down, btn_right, btn_left,
		       btn_r2, btn_l2, stick_x, stick_y,
		output ready
	);
endinterface

interface gpmix_whl_if;
	logic                                valid;
	logic                                ready;
	logic signed [gpmix_pkg::WHEEL_W-1:0] wheel1_rpm;
	logic signed [gpmix_pkg::WHEEL_W-1:0] wheel2_rpm;
	logic signed [gpmix_pkg::WHEEL_W-1:0] wheel3_rpm;
	logic signed [gpmix_pkg::WHEEL_W-1:0] wheel4_rpm;
	logic [gpmix_pkg::LED_W-1:0]          led_pattern;

	modport source (
		output valid, wheel1_rpm, wheel2_rpm, wheel3_rpm, wheel4_rpm, led_pattern,
		input  ready
	);
	modport sink (
		input  valid, wheel1_rpm, wheel2_rpm, wheel3_rpm, wheel4_rpm, led_pattern,
		output ready
	);
endinterface

`default_nettype wire

### design/gpmix_slope_div.sv
// ---------------------------------------------------------------------------
// gpmix_slope_div
// Restoring divider, one quotient bit per cycle, for the stick map slope.
// ---------------------------------------------------------------------------
`default_nettype none

module gpmix_slope_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [gpmix_pkg::RPM_W-1:0]   dividend,
	input  wire logic [gpmix_pkg::AXIS_W-1:0]  divisor,
	output logic                               busy,
	output logic [gpmix_pkg::RPM_W-1:0]        quotient
);

	localparam int STEPS = gpmix_pkg::RPM_W;
	localparam int CNT_W = $clog2(STEPS + 1);
	localparam int REM_W = gpmix_pkg::AXIS_W;

	logic                           start_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [REM_W-1:0]               rem_q;
	logic [gpmix_pkg::RPM_W-1:0]    work_q;
	logic [gpmix_pkg::RPM_W-1:0]    quo_q;

	logic [REM_W:0]                 shifted;
	logic [REM_W+1:0]               diff;
	logic                           qbit;
	logic [REM_W-1:0]               rem_nxt;
	logic [gpmix_pkg::RPM_W-1:0]    work_nxt;

	// one trial subtraction
	always_comb begin
		shifted  = {rem_q, work_q[gpmix_pkg::RPM_W-1]};
		diff     = {1'b0, shifted} - {2'b00, divisor};
		qbit     = ~diff[REM_W+1];
		rem_nxt  = qbit ? diff[REM_W-1:0] : shifted[REM_W-1:0];
		work_nxt = {work_q[gpmix_pkg::RPM_W-2:0], qbit};
	end

	// control and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			cnt_q   <= '0;
			quo_q   <= gpmix_pkg::RPM_W'(gpmix_pkg::SLOPE_RST);
		end else begin
			start_q <= start;
			if (start_q) begin
				cnt_q <= CNT_W'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					quo_q <= work_nxt;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start_q) begin
			rem_q  <= '0;
			work_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q  <= rem_nxt;
			work_q <= work_nxt;
		end
	end

	assign busy     = start | start_q | (cnt_q != '0);
	assign quotient = quo_q;

endmodule

`default_nettype wire

### design/gamepad_to_four_wheel_velocity_mixer.sv
// An accepted pad beat moves through stage registers 1 to 3 into the output register.
// One beat per cycle while wheels.ready is high and no slope recompute runs; stages
// stall independently and empty stages fill. A deadband or stick max write drops
// pad.ready while the stick slope is recomputed: write, operand load, divider steps.
// Reset (arst_n low, async): pipeline empty, registers at 50 / 1500 / 1000 / 0.
// ---------------------------------------------------------------------------
// gamepad_to_four_wheel_velocity_mixer
// Four-stage pipeline: button priority and stick dead band, products,
// scaling and stick map, wheel sign mixing into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module gamepad_to_four_wheel_velocity_mixer (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	gpmix_pad_if.sink                                 pad,
	gpmix_whl_if.source                               wheels,
	input  wire logic                                 cfg_we,
	input  wire logic [gpmix_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [gpmix_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int BW = gpmix_pkg::BTN_W;
	localparam int AW = gpmix_pkg::AXIS_W;
	localparam int RW = gpmix_pkg::RPM_W;
	localparam int PW = gpmix_pkg::PROD_W;
	localparam int MW = gpmix_pkg::MAP_W;
	localparam int WW = gpmix_pkg::WHEEL_W;
	localparam int LW = gpmix_pkg::LED_W;

	// configuration registers
	logic [AW-1:0] deadband_q;
	logic [RW-1:0] stick_max_q;
	logic [RW-1:0] btn_max_q;
	logic [BW-1:0] btn_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q  <= AW'(gpmix_pkg::RST_DEADBAND);
			stick_max_q <= RW'(gpmix_pkg::RST_STICK_MAX);
			btn_max_q   <= RW'(gpmix_pkg::RST_BTN_MAX);
			btn_thr_q   <= BW'(gpmix_pkg::RST_BTN_THR);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gpmix_pkg::REG_DEADBAND:  deadband_q  <= cfg_data[AW-1:0];
				gpmix_pkg::REG_STICK_MAX: stick_max_q <= cfg_data[RW-1:0];
				gpmix_pkg::REG_BTN_MAX:   btn_max_q   <= cfg_data[RW-1:0];
				gpmix_pkg::REG_BTN_THR:   btn_thr_q   <= cfg_data[BW-1:0];
			endcase
		end
	end

	// stick slope, recomputed after a write to either input
	logic [AW-1:0] half_db;
	logic [AW-1:0] slope_divisor;
	logic [AW-1:0] dz_hi;
	logic          slope_start;
	logic          slope_busy;
	logic [RW-1:0] slope;

	assign half_db       = {1'b0, deadband_q[AW-1:1]};
	assign slope_divisor = AW'(gpmix_pkg::DEADZONE_BASE) - half_db;
	assign dz_hi         = AW'(127) + half_db;
	assign slope_start   = cfg_we && (cfg_index == gpmix_pkg::REG_DEADBAND ||
	                                  cfg_index == gpmix_pkg::REG_STICK_MAX);

	gpmix_slope_div u_slope_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (slope_start),
		.dividend (stick_max_q),
		.divisor  (slope_divisor),
		.busy     (slope_busy),
		.quotient (slope)
	);

	// stage advance: a stage moves when empty or when its successor moves
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = ~v_s4 | wheels.ready;
	assign en3 = ~v_s3 | en4;
	assign en2 = ~v_s2 | en3;
	assign en1 = ~v_s1 | en2;
	assign pad.ready = en1 & ~slope_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pad.valid & pad.ready;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: button priority, stick dead band regions
	gpmix_pkg::mode_t mode_c;
	logic [BW-1:0]    btn_c;
	logic             x_lt_c, x_gt_c, y_lt_c, y_gt_c;

	always_comb begin
		btn_c = pad.btn_up;
		priority if (!pad.connected) begin
			mode_c = gpmix_pkg::MODE_OFF;
		end else if (pad.btn_up > btn_thr_q) begin
			mode_c = gpmix_pkg::MODE_UP;
		end else if (pad.btn_down > btn_thr_q) begin
			mode_c = gpmix_pkg::MODE_DOWN;
			btn_c  = pad.btn_down;
		end else if (pad.btn_right > btn_thr_q) begin
			mode_c = gpmix_pkg::MODE_RIGHT;
			btn_c  = pad.btn_right;
		end else if (pad.btn_left > btn_thr_q) begin
			mode_c = gpmix_pkg::MODE_LEFT;
			btn_c  = pad.btn_left;
		end else if (pad.btn_r2 > btn_thr_q) begin
			mode_c = gpmix_pkg::MODE_R2;
			btn_c  = pad.btn_r2;
		end else if (pad.btn_l2 > btn_thr_q) begin
			mode_c = gpmix_pkg::MODE_L2;
			btn_c  = pad.btn_l2;
		end else begin
			mode_c = gpmix_pkg::MODE_STICK;
		end
		// v < 126 - d/2  <=>  v + d/2 < 126
		x_lt_c = ({1'b0, pad.stick_x} + {1'b0, half_db}) < (AW+1)'(126);
		y_lt_c = ({1'b0, pad.stick_y} + {1'b0, half_db}) < (AW+1)'(126);
		x_gt_c = pad.stick_x > dz_hi;
		y_gt_c = pad.stick_y > dz_hi;
	end

	gpmix_pkg::mode_t mode_s1;
	logic [BW-1:0]    btn_s1;
	logic [AW-1:0]    xop_s1, yop_s1;
	logic             x_lt_s1, x_gt_s1, y_lt_s1, y_gt_s1;

	// multiplier operand is v below the dead zone and 255 - v above it
	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1 <= mode_c;
			btn_s1  <= btn_c;
			xop_s1  <= x_lt_c ? pad.stick_x : ~pad.stick_x;
			yop_s1  <= y_lt_c ? pad.stick_y : ~pad.stick_y;
			x_lt_s1 <= x_lt_c;
			x_gt_s1 <= x_gt_c;
			y_lt_s1 <= y_lt_c;
			y_gt_s1 <= y_gt_c;
		end
	end

	// stage 2: button and stick products
	gpmix_pkg::mode_t mode_s2;
	logic [PW-1:0]    bprod_s2, xprod_s2, yprod_s2;
	logic             x_lt_s2, x_gt_s2, y_lt_s2, y_gt_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			mode_s2  <= mode_s1;
			bprod_s2 <= PW'(btn_s1) * PW'(btn_max_q);
			xprod_s2 <= PW'(slope) * PW'(xop_s1);
			yprod_s2 <= PW'(slope) * PW'(yop_s1);
			x_lt_s2  <= x_lt_s1;
			x_gt_s2  <= x_gt_s1;
			y_lt_s2  <= y_lt_s1;
			y_gt_s2  <= y_gt_s1;
		end
	end

	// stage 3: divide by 255 and finish the stick map
	// p = 256a + b, so p/255 = a + (a + b)/255; fold once more and correct by one
	logic [RW-1:0]   div_a;
	logic [RW:0]     div_ab;
	logic [AW:0]     div_ce;
	logic [RW:0]     div_q;
	logic signed [PW:0] x_lo, x_hi, y_lo, y_hi;
	logic signed [MW-1:0] fx_c, fy_c;

	always_comb begin
		div_a  = bprod_s2[PW-1:AW];
		div_ab = {1'b0, div_a} + (RW+1)'(bprod_s2[AW-1:0]);
		div_ce = (AW+1)'(div_ab[RW:AW]) + (AW+1)'(div_ab[AW-1:0]);
		div_q  = (RW+1)'(div_a) + (RW+1)'(div_ab[RW:AW]) +
		         (RW+1)'(div_ce >= (AW+1)'(gpmix_pkg::AXIS_FULL_SCALE));

		x_lo = $signed({1'b0, xprod_s2}) - $signed((PW+1)'(stick_max_q));
		x_hi = $signed((PW+1)'(stick_max_q)) - $signed({1'b0, xprod_s2});
		y_lo = $signed({1'b0, yprod_s2}) - $signed((PW+1)'(stick_max_q));
		y_hi = $signed((PW+1)'(stick_max_q)) - $signed({1'b0, yprod_s2});

		if (x_lt_s2)      fx_c = x_lo[MW-1:0];
		else if (x_gt_s2) fx_c = x_hi[MW-1:0];
		else              fx_c = '0;
		if (y_lt_s2)      fy_c = y_lo[MW-1:0];
		else if (y_gt_s2) fy_c = y_hi[MW-1:0];
		else              fy_c = '0;
	end

	gpmix_pkg::mode_t     mode_s3;
	logic [RW-1:0]        rpm_s3;
	logic signed [MW-1:0] fx_s3, fy_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			mode_s3 <= mode_s2;
			rpm_s3  <= div_q[RW-1:0];
			fx_s3   <= fx_c;
			fy_s3   <= fy_c;
		end
	end

	// stage 4: wheel signs and LED pattern
	// stick: l = fx - fy, r = -(fx + fy); wheels -r, -r, l, l
	logic signed [WW-1:0] pos_c, neg_c, sum_c, dif_c;
	logic signed [WW-1:0] w1_c, w2_c, w3_c, w4_c;
	logic [LW-1:0]        led_c;

	always_comb begin
		pos_c = $signed(WW'(rpm_s3));
		neg_c = -pos_c;
		sum_c = WW'(fx_s3) + WW'(fy_s3);
		dif_c = WW'(fx_s3) - WW'(fy_s3);
		unique case (mode_s3)
			gpmix_pkg::MODE_OFF: begin
				w1_c = '0; w2_c = '0; w3_c = '0; w4_c = '0;
				led_c = gpmix_pkg::LED_IDLE;
			end
			gpmix_pkg::MODE_UP: begin
				w1_c = neg_c; w2_c = neg_c; w3_c = pos_c; w4_c = pos_c;
				led_c = gpmix_pkg::LED_FWD;
			end
			gpmix_pkg::MODE_DOWN: begin
				w1_c = pos_c; w2_c = pos_c; w3_c = neg_c; w4_c = neg_c;
				led_c = gpmix_pkg::LED_BWD;
			end
			gpmix_pkg::MODE_RIGHT: begin
				w1_c = pos_c; w2_c = neg_c; w3_c = neg_c; w4_c = pos_c;
				led_c = gpmix_pkg::LED_RGT;
			end
			gpmix_pkg::MODE_LEFT: begin
				w1_c = neg_c; w2_c = pos_c; w3_c = pos_c; w4_c = neg_c;
				led_c = gpmix_pkg::LED_LFT;
			end
			gpmix_pkg::MODE_R2: begin
				w1_c = pos_c; w2_c = pos_c; w3_c = pos_c; w4_c = pos_c;
				led_c = gpmix_pkg::LED_IDLE;
			end
			gpmix_pkg::MODE_L2: begin
				w1_c = neg_c; w2_c = neg_c; w3_c = neg_c; w4_c = neg_c;
				led_c = gpmix_pkg::LED_IDLE;
			end
			gpmix_pkg::MODE_STICK: begin
				w1_c = sum_c; w2_c = sum_c; w3_c = dif_c; w4_c = dif_c;
				if (dif_c > 0 && sum_c < 0)      led_c = gpmix_pkg::LED_FWD;
				else if (dif_c < 0 && sum_c > 0) led_c = gpmix_pkg::LED_BWD;
				else                             led_c = gpmix_pkg::LED_IDLE;
			end
		endcase
	end

	logic signed [WW-1:0] w1_s4, w2_s4, w3_s4, w4_s4;
	logic [LW-1:0]        led_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			w1_s4  <= w1_c;
			w2_s4  <= w2_c;
			w3_s4  <= w3_c;
			w4_s4  <= w4_c;
			led_s4 <= led_c;
		end
	end

	// output beat
	assign wheels.valid       = v_s4;
	assign wheels.wheel1_rpm  = w1_s4;
	assign wheels.wheel2_rpm  = w2_s4;
	assign wheels.wheel3_rpm  = w3_s4;
	assign wheels.wheel4_rpm  = w4_s4;
	assign wheels.led_pattern = led_s4;

	// checks
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		slope_busy |-> !pad.ready)
		else $error("pad beat accepted while stick slope is recomputed");

	a_write_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		slope_start |=> slope_busy)
		else $error("slope divider did not start after a register write");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(slope_busy) |-> cfg_we)
		else $error("slope divider started without a register write");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pad.valid && pad.ready) |=> v_s1)
		else $error("accepted pad beat did not enter stage 1");

	a_fill_output: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !v_s4) |=> v_s4)
		else $error("stage 3 beat did not move into the empty output register");

endmodule

`default_nettype wire
